[hw/rtl/asc_pkg.sv]
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types, constants and arithmetic helpers of the step size controller.
// ----------------------------------------------------------------------------
package asc_pkg;

   localparam int LOG_W      = 24;
   localparam int GAIN_W     = 16;
   localparam int GAIN_FRAC  = GAIN_W - 2;
   localparam int CNT_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = LOG_W;

   // difference of up to three log values, gain product, rounded term, sum
   localparam int DIFF_W = LOG_W + 3;
   localparam int PROD_W = DIFF_W + GAIN_W + 1;
   localparam int TERM_W = PROD_W - GAIN_FRAC;
   localparam int SUM_W  = TERM_W + 3;

   localparam logic signed [LOG_W-1:0] ERR_INIT_LOG2  = LOG_W'(-653130);
   localparam logic signed [LOG_W-1:0] INIT_STEP_LOG2 = LOG_W'(-435420);

   localparam logic signed [SUM_W-1:0] SUM_LOG_MAX =
      {{(SUM_W-LOG_W+1){1'b0}}, {(LOG_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_LOG_MIN =
      {{(SUM_W-LOG_W+1){1'b1}}, {(LOG_W-1){1'b0}}};

   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_FRAC - 1);

   typedef enum logic [1:0] {
      MODE_I   = 2'd0,
      MODE_PI  = 2'd1,
      MODE_PID = 2'd2,
      MODE_PC  = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MODE      = 3'd0,
      REG_TOLERANCE = 3'd1,
      REG_SAFETY    = 3'd2,
      REG_MAX_SCALE = 3'd3,
      REG_MIN_SCALE = 3'd4,
      REG_GAIN_P    = 3'd5,
      REG_GAIN_I    = 3'd6,
      REG_GAIN_D    = 3'd7
   } csr_index_type;

   typedef struct packed {
      mode_type                  mode;
      logic signed [LOG_W-1:0]   tolerance_log2;
      logic signed [LOG_W-1:0]   safety_log2;
      logic signed [LOG_W-1:0]   max_scale_log2;
      logic signed [LOG_W-1:0]   min_scale_log2;
      logic        [GAIN_W-1:0]  gain_proportional;
      logic        [GAIN_W-1:0]  gain_integral;
      logic        [GAIN_W-1:0]  gain_derivative;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mode:              MODE_PI,
      tolerance_log2:    LOG_W'(-653130),
      safety_log2:       LOG_W'(-9962),
      max_scale_log2:    LOG_W'(65536),
      min_scale_log2:    LOG_W'(-65536),
      gain_proportional: GAIN_W'(1229),
      gain_integral:     GAIN_W'(2867),
      gain_derivative:   GAIN_W'(0)
   };

   // d * g / 2^GAIN_FRAC, rounded to nearest, ties away from zero
   function automatic logic signed [TERM_W-1:0] gain_mul(
      input logic signed [DIFF_W-1:0] d,
      input logic        [GAIN_W-1:0] g
   );
      logic signed [PROD_W-1:0] p;
      logic        [PROD_W-1:0] mag;
      logic        [PROD_W-1:0] q;
      p   = PROD_W'(d) * $signed({1'b0, g});
      mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      q   = (mag + ROUND_HALF) >> GAIN_FRAC;
      return p[PROD_W-1] ? -$signed(TERM_W'(q)) : $signed(TERM_W'(q));
   endfunction

   function automatic logic signed [LOG_W-1:0] sat_log(input logic signed [SUM_W-1:0] v);
      if (v > SUM_LOG_MAX) begin
         return SUM_LOG_MAX[LOG_W-1:0];
      end else if (v < SUM_LOG_MIN) begin
         return SUM_LOG_MIN[LOG_W-1:0];
      end
      return v[LOG_W-1:0];
   endfunction

endpackage

[hw/rtl/asc_intf.sv]
// ----------------------------------------------------------------------------
// asc channel interfaces
// Valid/ready channels for error beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface asc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [asc_pkg::LOG_W-1:0]    err_log2;

   modport source (output valid, output err_log2, input ready);
   modport sink   (input valid, input err_log2, output ready);
endinterface

interface asc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                accepted;
   logic signed [asc_pkg::LOG_W-1:0]    next_step_log2;
   logic        [asc_pkg::CNT_W-1:0]    rejections;

   modport source (output valid, output accepted, output next_step_log2,
                   output rejections, input ready);
   modport sink   (input valid, input accepted, input next_step_log2,
                   input rejections, output ready);
endinterface

interface asc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [asc_pkg::CSR_IDX_W-1:0]       index;
   logic [asc_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/adaptive_step_size_controller_top.sv]
// ----------------------------------------------------------------------------
// adaptive_step_size_controller_top
// I / PI / PID / predictive step size controller in the log2 domain.
// ----------------------------------------------------------------------------
// req_bus carries one beat per solver step: log2 of the step's error estimate.
// rsp_bus returns one beat per request: accept flag, log2 of the next step
// size (clamped to the min/max scale window around the current step) and the
// saturating count of rejected steps so far.
// csr_bus writes the eight controller registers; it is always ready and is
// meant to be used while no request is in flight.
// A request beat passes an input register and a result register on its way
// to rsp_bus. Throughput: one beat per cycle while rsp_bus is ready; the step
// and error history update in the same cycle that a result is registered, so
// the next beat sees them at once.
// Reset clears the registers to their defaults, the error history to log2 of
// 1e-3, both step values to the initial step and the rejection count to zero.
// When rsp_bus stalls, the result register holds and one more request is taken
// into the input register; then req_bus.ready follows rsp_bus.ready.
// ----------------------------------------------------------------------------
module adaptive_step_size_controller_top (
   input  logic          clock,
   input  logic          reset,
   asc_req_if.sink       req_bus,
   asc_rsp_if.source     rsp_bus,
   asc_csr_if.sink       csr_bus
);

   asc_pkg::cfg_type cfg;

   asc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // input stage
   logic                               in_valid_ff, in_valid_in;
   logic signed [asc_pkg::LOG_W-1:0]   in_err_ff;

   // controller state
   logic signed [asc_pkg::LOG_W-1:0]   last_err_ff, prev_err_ff;
   logic signed [asc_pkg::LOG_W-1:0]   step_ff, acc_step_ff;
   logic        [asc_pkg::CNT_W-1:0]   reject_count_ff, reject_count_in;

   // result stage
   logic                               out_valid_ff, out_valid_in;
   logic                               out_acc_ff;
   logic signed [asc_pkg::LOG_W-1:0]   out_step_ff;
   logic        [asc_pkg::CNT_W-1:0]   out_rej_ff;

   logic advance;
   logic fire;
   logic req_fire;

   logic signed [asc_pkg::DIFF_W-1:0]  diff_i, diff_p, diff_d;
   logic signed [asc_pkg::TERM_W-1:0]  term_i, term_p, term_d;
   logic signed [asc_pkg::SUM_W-1:0]   base, sum;
   logic signed [asc_pkg::LOG_W-1:0]   s_sat, bound_hi, bound_lo, next_step;
   logic                               acc;

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign fire          = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = fire || (out_valid_ff && !rsp_bus.ready);

   always_comb begin
      diff_i = asc_pkg::DIFF_W'(cfg.tolerance_log2) - asc_pkg::DIFF_W'(in_err_ff);
      diff_p = asc_pkg::DIFF_W'(last_err_ff) - asc_pkg::DIFF_W'(in_err_ff);
      diff_d = (asc_pkg::DIFF_W'(last_err_ff) <<< 1) - asc_pkg::DIFF_W'(in_err_ff)
             - asc_pkg::DIFF_W'(prev_err_ff);
      term_i = asc_pkg::gain_mul(diff_i, cfg.gain_integral);
      term_p = asc_pkg::gain_mul(diff_p, cfg.gain_proportional);
      term_d = asc_pkg::gain_mul(diff_d, cfg.gain_derivative);

      if (cfg.mode == asc_pkg::MODE_PC) begin
         base = (asc_pkg::SUM_W'(step_ff) <<< 1) - asc_pkg::SUM_W'(acc_step_ff);
      end else begin
         base = asc_pkg::SUM_W'(step_ff);
      end

      sum = base + asc_pkg::SUM_W'(cfg.safety_log2) + asc_pkg::SUM_W'(term_i);
      if (cfg.mode != asc_pkg::MODE_I) begin
         sum = sum + asc_pkg::SUM_W'(term_p);
      end
      if (cfg.mode == asc_pkg::MODE_PID) begin
         sum = sum + asc_pkg::SUM_W'(term_d);
      end
      s_sat = asc_pkg::sat_log(sum);

      bound_hi = asc_pkg::sat_log(asc_pkg::SUM_W'(step_ff)
                                  + asc_pkg::SUM_W'(cfg.max_scale_log2));
      bound_lo = asc_pkg::sat_log(asc_pkg::SUM_W'(step_ff)
                                  + asc_pkg::SUM_W'(cfg.min_scale_log2));

      // max bound wins when the window is inverted
      next_step = (s_sat < bound_lo) ? bound_lo : s_sat;
      if (next_step > bound_hi) begin
         next_step = bound_hi;
      end

      acc = in_err_ff <= cfg.tolerance_log2;

      reject_count_in = reject_count_ff;
      if (!acc && (reject_count_ff != {asc_pkg::CNT_W{1'b1}})) begin
         reject_count_in = reject_count_ff + asc_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         last_err_ff     <= asc_pkg::ERR_INIT_LOG2;
         prev_err_ff     <= asc_pkg::ERR_INIT_LOG2;
         step_ff         <= asc_pkg::INIT_STEP_LOG2;
         acc_step_ff     <= asc_pkg::INIT_STEP_LOG2;
         reject_count_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            step_ff         <= next_step;
            reject_count_ff <= reject_count_in;
            if (acc) begin
               prev_err_ff <= last_err_ff;
               last_err_ff <= in_err_ff;
               acc_step_ff <= next_step;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_err_ff <= req_bus.err_log2;
      end
      if (fire) begin
         out_acc_ff  <= acc;
         out_step_ff <= next_step;
         out_rej_ff  <= reject_count_in;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.accepted       = out_acc_ff;
   assign rsp_bus.next_step_log2 = out_step_ff;
   assign rsp_bus.rejections     = out_rej_ff;

   // rejection count never goes down
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> reject_count_ff >= $past(reject_count_ff))
      else $error("rejection count decreased");

   // an accepted step enters the error history
   assert property (@(posedge clock) disable iff (reset)
      (fire && acc) |=> (last_err_ff == $past(in_err_ff))
                        && (prev_err_ff == $past(last_err_ff)))
      else $error("error history not shifted on accepted step");

   // a rejected step leaves the error history alone
   assert property (@(posedge clock) disable iff (reset)
      (fire && !acc) |=> $stable(last_err_ff) && $stable(prev_err_ff)
                         && $stable(acc_step_ff))
      else $error("error history changed on rejected step");

   // the pending result always carries the current step
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_step_ff == step_ff))
      else $error("result step differs from controller step");

endmodule

[hw/rtl/asc_csr.sv]
// ----------------------------------------------------------------------------
// asc_csr
// Controller configuration registers, written one beat at a time.
// ----------------------------------------------------------------------------
module asc_csr (
   input  logic               clock,
   input  logic               reset,
   asc_csr_if.sink            csr_bus,
   output asc_pkg::cfg_type   cfg
);

   asc_pkg::cfg_type cfg_ff;
   asc_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            asc_pkg::REG_MODE: begin
               cfg_in.mode = asc_pkg::mode_type'(csr_bus.data[1:0]);
            end
            asc_pkg::REG_TOLERANCE: begin
               cfg_in.tolerance_log2 = $signed(csr_bus.data[asc_pkg::LOG_W-1:0]);
            end
            asc_pkg::REG_SAFETY: begin
               cfg_in.safety_log2 = $signed(csr_bus.data[asc_pkg::LOG_W-1:0]);
            end
            asc_pkg::REG_MAX_SCALE: begin
               cfg_in.max_scale_log2 = $signed(csr_bus.data[asc_pkg::LOG_W-1:0]);
            end
            asc_pkg::REG_MIN_SCALE: begin
               cfg_in.min_scale_log2 = $signed(csr_bus.data[asc_pkg::LOG_W-1:0]);
            end
            asc_pkg::REG_GAIN_P: begin
               cfg_in.gain_proportional = csr_bus.data[asc_pkg::GAIN_W-1:0];
            end
            asc_pkg::REG_GAIN_I: begin
               cfg_in.gain_integral = csr_bus.data[asc_pkg::GAIN_W-1:0];
            end
            asc_pkg::REG_GAIN_D: begin
               cfg_in.gain_derivative = csr_bus.data[asc_pkg::GAIN_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= asc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[bench/adaptive_step_size_controller_top_tb.sv]
// ----------------------------------------------------------------------------
// adaptive_step_size_controller_top_tb
// Self-checking bench for the log2-domain step size controller. Error beats
// are driven with random gaps, results are drained with random stalls and one
// long hold-off. A scoreboard predicts accept flag, next step and rejection
// count for every accepted error beat and checks each result beat in order.
// Directed beats cover field extremes, all four modes, saturation, inverted
// scale bounds and runs of rejected steps. Random phases follow, under
// several register settings.
// ----------------------------------------------------------------------------
module adaptive_step_size_controller_top_tb;

   localparam longint STEP_LOG_MAX   = (64'sd1 <<< (asc_pkg::LOG_W - 1)) - 1;
   localparam longint STEP_LOG_MIN   = -STEP_LOG_MAX - 1;
   localparam longint ERR_START_LOG2 = -653130;
   localparam longint STEP_START     = -435420;
   localparam int     HOLD_OFF_CYCLES = 300;
   localparam int     WATCHDOG_LIMIT  = 4000;

   class step_size_scoreboard;
      typedef struct {
         logic                             accepted;
         logic signed [asc_pkg::LOG_W-1:0] next_step_log2;
         logic [asc_pkg::CNT_W-1:0]        rejections;
      } step_outcome_type;

      asc_pkg::mode_type  mode;
      longint             tolerance_log2, safety_log2, max_scale_log2, min_scale_log2;
      longint             gain_p, gain_i, gain_d;
      longint             last_err, prev_err, step, accepted_step;
      int unsigned        reject_count;
      step_outcome_type   outcome_q[$];
      int                 mismatches;

      function new();
         mode           = asc_pkg::MODE_PI;
         tolerance_log2 = -653130;
         safety_log2    = -9962;
         max_scale_log2 = 65536;
         min_scale_log2 = -65536;
         gain_p         = 1229;
         gain_i         = 2867;
         gain_d         = 0;
         last_err       = ERR_START_LOG2;
         prev_err       = ERR_START_LOG2;
         step           = STEP_START;
         accepted_step  = STEP_START;
         reject_count   = 0;
         mismatches     = 0;
      endfunction

      function longint clip(longint v);
         if (v > STEP_LOG_MAX) return STEP_LOG_MAX;
         if (v < STEP_LOG_MIN) return STEP_LOG_MIN;
         return v;
      endfunction

      // round(d * g / 2^GAIN_FRAC), ties away from zero
      function longint gain_term(longint d, longint g);
         longint mag;
         longint q;
         mag = (d < 0) ? -d : d;
         q = (mag * g + (64'sd1 <<< (asc_pkg::GAIN_FRAC - 1))) >>> asc_pkg::GAIN_FRAC;
         return (d < 0) ? -q : q;
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction

      function void write_reg(asc_pkg::csr_index_type idx,
                              logic [asc_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            asc_pkg::REG_MODE:
               mode = asc_pkg::mode_type'(data[1:0]);
            asc_pkg::REG_TOLERANCE:
               tolerance_log2 = longint'($signed(data[asc_pkg::LOG_W-1:0]));
            asc_pkg::REG_SAFETY:
               safety_log2 = longint'($signed(data[asc_pkg::LOG_W-1:0]));
            asc_pkg::REG_MAX_SCALE:
               max_scale_log2 = longint'($signed(data[asc_pkg::LOG_W-1:0]));
            asc_pkg::REG_MIN_SCALE:
               min_scale_log2 = longint'($signed(data[asc_pkg::LOG_W-1:0]));
            asc_pkg::REG_GAIN_P:
               gain_p = longint'(data[asc_pkg::GAIN_W-1:0]);
            asc_pkg::REG_GAIN_I:
               gain_i = longint'(data[asc_pkg::GAIN_W-1:0]);
            asc_pkg::REG_GAIN_D:
               gain_d = longint'(data[asc_pkg::GAIN_W-1:0]);
            default: ;
         endcase
      endfunction

      function void note_error(logic signed [asc_pkg::LOG_W-1:0] err_log2);
         longint           e, s, hi, lo, next;
         step_outcome_type o;
         e = err_log2;
         s = safety_log2 + gain_term(tolerance_log2 - e, gain_i);
         if (mode != asc_pkg::MODE_I) s += gain_term(last_err - e, gain_p);
         if (mode == asc_pkg::MODE_PID)
            s += gain_term(2 * last_err - e - prev_err, gain_d);
         if (mode == asc_pkg::MODE_PC) s += 2 * step - accepted_step;
         else s += step;
         s = clip(s);
         hi = clip(step + max_scale_log2);
         lo = clip(step + min_scale_log2);
         next = (s < lo) ? lo : s;
         if (next > hi) next = hi;
         o.accepted = (e <= tolerance_log2);
         if (o.accepted) begin
            prev_err      = last_err;
            last_err      = e;
            accepted_step = next;
         end else if (reject_count < 65535) begin
            reject_count++;
         end
         step = next;
         o.next_step_log2 = asc_pkg::LOG_W'(next);
         o.rejections     = asc_pkg::CNT_W'(reject_count);
         outcome_q.push_back(o);
      endfunction

      function void check_result(logic acc, logic signed [asc_pkg::LOG_W-1:0] next,
                                 logic [asc_pkg::CNT_W-1:0] rej);
         step_outcome_type o;
         if (outcome_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: acc=%0d next=%0d rej=%0d",
                        acc, next, rej);
            return;
         end
         o = outcome_q.pop_front();
         if (acc !== o.accepted || next !== o.next_step_log2 || rej !== o.rejections) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected acc=%0d next=%0d rej=%0d, got acc=%0d next=%0d rej=%0d",
                        o.accepted, o.next_step_log2, o.rejections, acc, next, rej);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   asc_req_if req_bus ();
   asc_rsp_if rsp_bus ();
   asc_csr_if csr_bus ();

   adaptive_step_size_controller_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   step_size_scoreboard sb;
   bit src_idle_en;
   bit sink_idle_en;
   bit hold_off_req;
   int idle_cycles;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // beat monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) sb.note_error(req_bus.err_log2);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.accepted, rsp_bus.next_step_log2, rsp_bus.rejections);
         if (csr_bus.valid && csr_bus.ready)
            sb.write_reg(asc_pkg::csr_index_type'(csr_bus.index), csr_bus.data);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic send_err(input longint e);
      int gap;
      req_bus.valid    <= 1'b1;
      req_bus.err_log2 <= asc_pkg::LOG_W'(e);
      do @(posedge clock); while (!req_bus.ready);
      gap = src_idle_en ? pick_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input asc_pkg::csr_index_type idx, input longint value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= asc_pkg::CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering beats and wait for every outstanding result
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_config(input bit wild);
      if (wild) begin
         write_reg(asc_pkg::REG_MODE, $urandom());
         write_reg(asc_pkg::REG_TOLERANCE, $urandom());
         write_reg(asc_pkg::REG_SAFETY, $urandom());
         write_reg(asc_pkg::REG_MAX_SCALE, $urandom());
         write_reg(asc_pkg::REG_MIN_SCALE, $urandom());
      end else begin
         write_reg(asc_pkg::REG_MODE, $urandom_range(0, 3));
         write_reg(asc_pkg::REG_TOLERANCE, -longint'($urandom_range(0, 1 << 20)));
         write_reg(asc_pkg::REG_SAFETY, -longint'($urandom_range(0, 1 << 15)));
         write_reg(asc_pkg::REG_MAX_SCALE, $urandom_range(0, 1 << 17));
         write_reg(asc_pkg::REG_MIN_SCALE, -longint'($urandom_range(0, 1 << 17)));
      end
      write_reg(asc_pkg::REG_GAIN_P, $urandom_range(0, 65535));
      write_reg(asc_pkg::REG_GAIN_I, $urandom_range(0, 65535));
      write_reg(asc_pkg::REG_GAIN_D, $urandom_range(0, 65535));
   endtask

   function automatic longint random_err();
      longint v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5:
            v = sb.clip(sb.tolerance_log2 + longint'($urandom_range(0, 1 << 18)) - (1 << 17));
         6, 7: v = longint'($signed(asc_pkg::LOG_W'($urandom())));
         8: v = sb.tolerance_log2;
         default: v = $urandom_range(0, 1) ? STEP_LOG_MAX : STEP_LOG_MIN;
      endcase
      return v;
   endfunction

   initial begin
      asc_pkg::mode_type modes [4];
      longint            e;
      modes = '{asc_pkg::MODE_I, asc_pkg::MODE_PI, asc_pkg::MODE_PID, asc_pkg::MODE_PC};
      sb = new();
      idle_cycles = 0;
      src_idle_en = 1'b0;
      sink_idle_en = 1'b0;
      hold_off_req = 1'b0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.err_log2 <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: at, just above and far from the tolerance
      send_err(-653130);
      send_err(-653129);
      send_err(STEP_LOG_MAX);
      send_err(STEP_LOG_MIN);
      send_err(0);
      send_err(-1);

      settle();
      write_reg(asc_pkg::REG_GAIN_D, 16384);
      for (int k = 0; k < 4; k++) begin
         settle();
         write_reg(asc_pkg::REG_MODE, modes[k]);
         send_err(STEP_LOG_MIN);
         send_err(STEP_LOG_MAX);
         send_err(sb.tolerance_log2);
      end

      // everything at the top: sums saturate
      settle();
      write_reg(asc_pkg::REG_MODE, asc_pkg::MODE_PID);
      write_reg(asc_pkg::REG_TOLERANCE, STEP_LOG_MAX);
      write_reg(asc_pkg::REG_SAFETY, STEP_LOG_MAX);
      write_reg(asc_pkg::REG_MAX_SCALE, STEP_LOG_MAX);
      write_reg(asc_pkg::REG_MIN_SCALE, STEP_LOG_MIN);
      write_reg(asc_pkg::REG_GAIN_P, 65535);
      write_reg(asc_pkg::REG_GAIN_I, 65535);
      write_reg(asc_pkg::REG_GAIN_D, 65535);
      send_err(STEP_LOG_MIN);
      send_err(STEP_LOG_MAX);

      // inverted scale window, max bound wins
      settle();
      write_reg(asc_pkg::REG_MIN_SCALE, 100000);
      write_reg(asc_pkg::REG_MAX_SCALE, -100000);
      send_err(STEP_LOG_MIN);
      send_err(0);

      for (int p = 0; p < 6; p++) begin
         settle();
         random_config(p == 3 || p == 5);
         src_idle_en = (p != 1);
         sink_idle_en = (p != 1);
         if (p == 2) hold_off_req = 1'b1;
         for (int i = 0; i < 140; i++) begin
            if (p == 4 && i == 70) settle();
            send_err(random_err());
         end
      end

      // lowest tolerance: every beat is rejected
      settle();
      src_idle_en = 1'b0;
      sink_idle_en = 1'b0;
      write_reg(asc_pkg::REG_TOLERANCE, STEP_LOG_MIN);
      repeat (20) begin
         e = longint'($signed(asc_pkg::LOG_W'($urandom())));
         if (e == STEP_LOG_MIN) e = 0;
         send_err(e);
      end
      settle();
      src_idle_en = 1'b1;
      sink_idle_en = 1'b1;
      write_reg(asc_pkg::REG_TOLERANCE, STEP_LOG_MAX);
      repeat (8) send_err(random_err());
      send_err(STEP_LOG_MIN);
      settle();
      write_reg(asc_pkg::REG_TOLERANCE, STEP_LOG_MIN);
      repeat (4) send_err(0);

      settle();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/asc_pkg.sv
hw/rtl/asc_intf.sv
hw/rtl/asc_csr.sv
hw/rtl/adaptive_step_size_controller_top.sv
bench/adaptive_step_size_controller_top_tb.sv
